>>> rtl/console_line_editor_defines.svh
// Assertion macros for the console line editor.
// Used by console_line_editor.sv; assumes clk and rst_n are in scope.
`ifndef CONSOLE_LINE_EDITOR_DEFINES_SVH
`define CONSOLE_LINE_EDITOR_DEFINES_SVH

// expression holds at every clock edge out of reset
`define CLE_ASSERT_HOLDS(label, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("console_line_editor: invariant violated");

// consequent holds in the same cycle as the antecedent
`define CLE_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("console_line_editor: same-cycle check failed");

// consequent holds in the cycle after the antecedent
`define CLE_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("console_line_editor: next-cycle check failed");

`endif

>>> rtl/cle_pkg.sv
// Shared constants for the console line editor.
// No dependencies; used by console_line_editor.sv.
`default_nettype none

package cle_pkg;

    parameter int LINE_CAPACITY_DEF = 128;
    parameter int CHAR_W            = 7;
    parameter int REP_W             = 8;
    parameter int KIND_W            = 2;

    // result kinds
    parameter logic [KIND_W-1:0] KIND_ECHO   = 2'd0;
    parameter logic [KIND_W-1:0] KIND_DATA   = 2'd1;
    parameter logic [KIND_W-1:0] KIND_REFUSE = 2'd2;

    // character codes
    parameter logic [CHAR_W-1:0] CHAR_NUL   = 7'h00;
    parameter logic [CHAR_W-1:0] CHAR_BS    = 7'h08;
    parameter logic [CHAR_W-1:0] CHAR_LF    = 7'h0A;
    parameter logic [CHAR_W-1:0] CHAR_CR    = 7'h0D;
    parameter logic [CHAR_W-1:0] CHAR_XON   = 7'h11;
    parameter logic [CHAR_W-1:0] CHAR_XOFF  = 7'h13;
    parameter logic [CHAR_W-1:0] CHAR_NAK   = 7'h15;
    parameter logic [CHAR_W-1:0] CHAR_CAN   = 7'h18;
    parameter logic [CHAR_W-1:0] CHAR_SPACE = 7'h20;
    parameter logic [CHAR_W-1:0] CHAR_HASH  = 7'h23;
    parameter logic [CHAR_W-1:0] CHAR_AT    = 7'h40;
    parameter logic [CHAR_W-1:0] CHAR_BSLASH = 7'h5C;
    parameter logic [CHAR_W-1:0] CHAR_DEL   = 7'h7F;

endpackage

`default_nettype wire

>>> rtl/cle_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
`default_nettype none

module cle_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

>>> rtl/console_line_editor.sv
// Cooked-mode console line editor, top level.
// Depends on cle_pkg, cle_ram and console_line_editor_defines.svh.
//
// Typed characters enter on the s_ side with s_tuser = 0 and edit the line in
// place: erase and kill produce echo transfers, CR/LF closes the line, NUL,
// XON and XOFF are dropped, other characters are stored without echo.
// Transfers with s_tuser = 1 fetch the closed line one character per transfer,
// the newline marked by m_tlast. A transfer yielding at most one result is
// taken every cycle while m_tready does not hold the output back; one yielding
// k results (erase and kill echoes: 2 or 3) holds s_tready low while the
// result queue drains one result per cycle into the output register, as
// m_tready allows. Every result passes the result queue and then the output
// register before it appears on m_tdata; the line store RAM is read at the
// accepting edge. No clearing pass is needed after reset. crt_mode may be
// written only while idle.
`default_nettype none

`include "console_line_editor_defines.svh"

module console_line_editor #(
    parameter int LINE_CAPACITY = cle_pkg::LINE_CAPACITY_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_wr_en,
    input  wire logic        cfg_wr_data,   // crt_mode
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,       // [6:0] typed_char, [7] unused
    input  wire logic [0:0]  s_tuser,       // [0] action
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,       // [6:0] out_char, [14:7] repeat_res, [15] zero
    output logic [1:0]       m_tuser,       // [1:0] kind
    output logic             m_tlast
);

    localparam int CHAR_W = cle_pkg::CHAR_W;
    localparam int REP_W  = cle_pkg::REP_W;
    localparam int KIND_W = cle_pkg::KIND_W;
    localparam int ADDR_W = $clog2(LINE_CAPACITY);
    localparam int LEN_W  = $clog2(LINE_CAPACITY + 1);
    localparam int RUN_W  = (LEN_W + 1 > REP_W) ? LEN_W + 1 : REP_W;

    localparam logic [LEN_W-1:0] CAP_LEN   = LEN_W'(LINE_CAPACITY);
    localparam logic [LEN_W-1:0] CAP_M1    = LEN_W'(LINE_CAPACITY - 1);
    localparam logic [RUN_W-1:0] RUN_MAX   = RUN_W'(255);

    typedef enum logic [2:0] {
        OP_REFUSE,
        OP_DATA,
        OP_ERASE_CRT,
        OP_ERASE_PRT,
        OP_KILL_CRT,
        OP_KILL_PRT
    } op_t;

    // state
    logic              crt_mode_reg;
    logic [LEN_W-1:0]  line_len_reg,  line_len_next;
    logic [LEN_W-1:0]  read_pos_reg,  read_pos_next;
    logic              line_done_reg, line_done_next;

    // result queue of the current transfer
    op_t               pend_op_reg;
    logic [1:0]        pend_cnt_reg;
    logic [1:0]        pend_idx_reg;
    logic [REP_W-1:0]  pend_run_reg;
    logic              pend_end_reg;

    // output register
    logic              out_valid_reg;
    logic [CHAR_W-1:0] out_char_reg;
    logic [REP_W-1:0]  out_rep_reg;
    logic [KIND_W-1:0] out_kind_reg;
    logic              out_last_reg;

    logic              s_accept;
    logic              out_load;
    logic [CHAR_W-1:0] c;

    op_t               new_op;
    logic [1:0]        new_cnt;
    logic [REP_W-1:0]  new_run;
    logic              new_end;

    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [CHAR_W-1:0] ram_wdata;
    logic [ADDR_W-1:0] ram_raddr;
    logic [CHAR_W-1:0] ram_rdata;

    logic [LEN_W-1:0]  len_m1;
    logic [LEN_W-1:0]  rp_p1;
    logic [RUN_W-1:0]  len_ext;

    logic [CHAR_W-1:0] res_char;
    logic [REP_W-1:0]  res_rep;
    logic [KIND_W-1:0] res_kind;
    logic              res_last;

    assign c        = s_tdata[CHAR_W-1:0];
    assign out_load = (pend_cnt_reg != 2'd0) && (!out_valid_reg || m_tready);
    assign s_tready = (pend_cnt_reg == 2'd0) || ((pend_cnt_reg == 2'd1) && out_load);
    assign s_accept = s_tvalid && s_tready;

    assign len_m1  = line_len_reg - LEN_W'(1);
    assign rp_p1   = read_pos_reg + LEN_W'(1);
    assign len_ext = RUN_W'(line_len_reg) + RUN_W'(1);

    cle_ram #(
        .WIDTH (CHAR_W),
        .DEPTH (LINE_CAPACITY)
    ) u_line_store (
        .clk     (clk),
        .wr_en   (ram_we && s_accept),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_en   (s_accept),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    // edit decode for one accepted transfer
    always_comb
    begin
        line_len_next  = line_len_reg;
        read_pos_next  = read_pos_reg;
        line_done_next = line_done_reg;
        new_op         = OP_REFUSE;
        new_cnt        = 2'd0;
        new_run        = REP_W'(1);
        new_end        = 1'b0;
        ram_we         = 1'b0;
        ram_waddr      = line_len_reg[ADDR_W-1:0];
        ram_wdata      = c;
        ram_raddr      = read_pos_reg[ADDR_W-1:0];

        if (s_tuser[0])
        begin
            if (!line_done_reg || (read_pos_reg >= line_len_reg))
            begin
                new_cnt = 2'd1;
            end
            else
            begin
                new_op        = OP_DATA;
                new_cnt       = 2'd1;
                new_end       = (rp_p1 >= line_len_reg);
                read_pos_next = rp_p1;
                if (rp_p1 >= line_len_reg)
                begin
                    line_done_next = 1'b0;
                    line_len_next  = '0;
                    read_pos_next  = '0;
                end
            end
        end
        else if (line_done_reg)
        begin
            new_cnt = 2'd1;
        end
        else
        begin
            unique case (c) inside
                cle_pkg::CHAR_NUL, cle_pkg::CHAR_XON, cle_pkg::CHAR_XOFF:
                begin
                end
                cle_pkg::CHAR_LF, cle_pkg::CHAR_CR:
                begin
                    if (line_len_reg < CAP_LEN)
                    begin
                        ram_we        = 1'b1;
                        ram_wdata     = cle_pkg::CHAR_LF;
                        line_len_next = line_len_reg + LEN_W'(1);
                    end
                    line_done_next = 1'b1;
                    read_pos_next  = '0;
                end
                cle_pkg::CHAR_DEL, cle_pkg::CHAR_BS, cle_pkg::CHAR_HASH:
                begin
                    if (line_len_reg != '0)
                    begin
                        line_len_next = len_m1;
                        ram_raddr     = len_m1[ADDR_W-1:0];
                        new_op        = crt_mode_reg ? OP_ERASE_CRT : OP_ERASE_PRT;
                        new_cnt       = crt_mode_reg ? 2'd3 : 2'd2;
                    end
                end
                cle_pkg::CHAR_AT, cle_pkg::CHAR_NAK, cle_pkg::CHAR_CAN:
                begin
                    new_run       = (len_ext > RUN_MAX) ? REP_W'(255) : len_ext[REP_W-1:0];
                    line_len_next = '0;
                    new_op        = crt_mode_reg ? OP_KILL_CRT : OP_KILL_PRT;
                    new_cnt       = crt_mode_reg ? 2'd3 : 2'd2;
                end
                default:
                begin
                    if (line_len_reg < CAP_M1)
                    begin
                        ram_we        = 1'b1;
                        line_len_next = line_len_reg + LEN_W'(1);
                    end
                end
            endcase
        end
    end

    // result at the head of the queue
    always_comb
    begin
        res_kind = cle_pkg::KIND_ECHO;
        res_char = cle_pkg::CHAR_NUL;
        res_rep  = REP_W'(1);
        res_last = (pend_cnt_reg == 2'd1);
        unique case (pend_op_reg)
            OP_REFUSE:
            begin
                res_kind = cle_pkg::KIND_REFUSE;
            end
            OP_DATA:
            begin
                res_kind = cle_pkg::KIND_DATA;
                res_char = ram_rdata;
                res_last = pend_end_reg;
            end
            OP_ERASE_CRT:
            begin
                res_char = (pend_idx_reg == 2'd1) ? cle_pkg::CHAR_SPACE : cle_pkg::CHAR_BS;
            end
            OP_ERASE_PRT:
            begin
                res_char = (pend_idx_reg == 2'd0) ? cle_pkg::CHAR_BSLASH : ram_rdata;
            end
            OP_KILL_CRT:
            begin
                res_char = (pend_idx_reg == 2'd1) ? cle_pkg::CHAR_SPACE : cle_pkg::CHAR_CR;
                res_rep  = (pend_idx_reg == 2'd1) ? pend_run_reg : REP_W'(1);
            end
            OP_KILL_PRT:
            begin
                res_char = (pend_idx_reg == 2'd0) ? cle_pkg::CHAR_AT : cle_pkg::CHAR_LF;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crt_mode_reg  <= 1'b1;
            line_len_reg  <= '0;
            read_pos_reg  <= '0;
            line_done_reg <= 1'b0;
            pend_op_reg   <= OP_REFUSE;
            pend_cnt_reg  <= 2'd0;
            pend_idx_reg  <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                crt_mode_reg <= cfg_wr_data;
            end

            if (s_accept)
            begin
                line_len_reg  <= line_len_next;
                read_pos_reg  <= read_pos_next;
                line_done_reg <= line_done_next;
                pend_op_reg   <= new_op;
                pend_cnt_reg  <= new_cnt;
                pend_idx_reg  <= 2'd0;
            end
            else if (out_load)
            begin
                pend_cnt_reg <= pend_cnt_reg - 2'd1;
                pend_idx_reg <= pend_idx_reg + 2'd1;
            end

            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            pend_run_reg <= new_run;
            pend_end_reg <= new_end;
        end
        if (out_load)
        begin
            out_char_reg <= res_char;
            out_rep_reg  <= res_rep;
            out_kind_reg <= res_kind;
            out_last_reg <= res_last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_rep_reg, out_char_reg};
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_last_reg;

    `CLE_ASSERT_IMPL(a_accept_queue_free, s_accept, pend_cnt_reg <= 2'd1)
    `CLE_ASSERT_HOLDS(a_done_line_nonempty, !line_done_reg || (line_len_reg != '0))
    `CLE_ASSERT_HOLDS(a_read_pos_in_line, read_pos_reg <= line_len_reg)
    `CLE_ASSERT_NEXT(a_refuse_while_done, s_accept && !s_tuser[0] && line_done_reg,
                     (pend_op_reg == OP_REFUSE) && (pend_cnt_reg == 2'd1))

endmodule

`default_nettype wire
